@@ rtl/core/msp_pkg.sv @@
// Package: shared constants and codes for the multi-stack shared pool.
`timescale 1ns / 1ps
package msp_pkg;
  localparam int NUM_STACKS = 8;
  localparam int POOL_NODES = 256;
  localparam int VALUE_W = 32;
  localparam int SEL_W = 3;
  localparam int NODE_W = $clog2(POOL_NODES + 1);
  localparam int ADDR_W = $clog2(POOL_NODES);
  localparam int STK_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int WORD_W = NODE_W + VALUE_W;
  localparam logic [NODE_W-1:0] NIL_NODE = NODE_W'(POOL_NODES);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;
endpackage

@@ rtl/core/multi_stack_shared_pool.sv @@
// Top level: several LIFO stacks over one shared pool of linked nodes.
//
// Input channel s_*: one beat per operation. s_tuser carries the operation
// (bit 0: 0 push, 1 pop) and the stack selector (bits 3:1); s_tdata carries
// the value to push (ignored for a pop).
// Output channel m_*: exactly one beat per operation. m_tdata carries the
// popped value (zero for a push or a failed pop); m_tuser carries the status
// (0 ok, 1 pop from an empty stack, 2 pool full on push). On error no state
// changes.
// In the accept cycle the read of the node word is issued (top node for a
// pop, free-list head for a push); in the execute state the registered read
// data is used, the node is written back and the output register is loaded.
// A new operation is not accepted until the current one leaves the execute
// state.
// The next beat is accepted while a result waits in the output register;
// if the receiver stalls, the following operation holds in the execute state
// until the output register is free.
// Reset (rst, synchronous) empties all stacks and the free list; the pool
// memory needs no clearing pass and no beat is lost to it.
`timescale 1ns / 1ps
module multi_stack_shared_pool (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // push_value[31:0]
  input  logic [3:0]  s_tuser,  // kind[0], stack_select[3:1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // pop_value[31:0]
  output logic [1:0]  m_tuser   // status[1:0]
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  logic [msp_pkg::NODE_W-1:0]  stack_top [msp_pkg::NUM_STACKS];
  logic [msp_pkg::NODE_W-1:0]  free_head;
  logic [msp_pkg::NODE_W-1:0]  fresh_next;

  logic [msp_pkg::WORD_W-1:0]  pool [msp_pkg::POOL_NODES];
  logic [msp_pkg::WORD_W-1:0]  rd_word;

  msp_pkg::op_t                op;
  logic [msp_pkg::STK_W-1:0]   op_stk;
  logic [msp_pkg::VALUE_W-1:0] op_value;
  msp_pkg::status_t            op_status;
  logic [msp_pkg::NODE_W-1:0]  op_node;
  logic                        op_from_free;

  logic                        s_fire;
  logic                        exec_go;
  msp_pkg::op_t                in_op;
  logic [msp_pkg::SEL_W-1:0]   in_sel;
  logic [msp_pkg::STK_W-1:0]   in_stk;
  logic                        in_sel_ok;
  logic [msp_pkg::NODE_W-1:0]  in_top;
  logic                        free_valid;
  logic                        fresh_left;
  msp_pkg::status_t            in_status;
  logic [msp_pkg::NODE_W-1:0]  in_node;

  logic                        wr_en;
  logic [msp_pkg::ADDR_W-1:0]  wr_addr;
  logic [msp_pkg::WORD_W-1:0]  wr_word;
  logic [msp_pkg::NODE_W-1:0]  rd_next;
  logic [msp_pkg::VALUE_W-1:0] rd_value;

  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign exec_go  = (state == S_EXEC) && (!m_tvalid || m_tready);

  assign in_op      = msp_pkg::op_t'(s_tuser[0]);
  assign in_sel     = s_tuser[3:1];
  assign in_stk     = msp_pkg::STK_W'(in_sel);
  assign in_sel_ok  = 32'(in_sel) < msp_pkg::NUM_STACKS;
  assign in_top     = stack_top[in_stk];
  assign free_valid = free_head < msp_pkg::NIL_NODE;
  assign fresh_left = fresh_next < msp_pkg::NIL_NODE;

  always_comb begin
    in_node   = free_valid ? free_head : fresh_next;
    in_status = msp_pkg::ST_OK;
    if (in_op == msp_pkg::OP_POP) begin
      in_node = in_top;
      if (!in_sel_ok || !(in_top < msp_pkg::NIL_NODE)) begin
        in_status = msp_pkg::ST_EMPTY;
      end
    end else if (!in_sel_ok || (!free_valid && !fresh_left)) begin
      in_status = msp_pkg::ST_FULL;
    end
  end

  assign rd_next  = rd_word[msp_pkg::WORD_W-1:msp_pkg::VALUE_W];
  assign rd_value = rd_word[msp_pkg::VALUE_W-1:0];
  assign wr_en    = exec_go && (op_status == msp_pkg::ST_OK);
  assign wr_addr  = op_node[msp_pkg::ADDR_W-1:0];
  assign wr_word  = (op == msp_pkg::OP_POP) ? {free_head, rd_value}
                                            : {stack_top[op_stk], op_value};

  always_ff @(posedge clk) begin
    if (s_fire) begin
      rd_word <= pool[in_node[msp_pkg::ADDR_W-1:0]];
    end
    if (wr_en) begin
      pool[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      op           <= in_op;
      op_stk       <= in_stk;
      op_value     <= s_tdata;
      op_status    <= in_status;
      op_node      <= in_node;
      op_from_free <= free_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      m_tdata    <= '0;
      m_tuser    <= msp_pkg::ST_OK;
      free_head  <= msp_pkg::NIL_NODE;
      fresh_next <= '0;
      for (int i = 0; i < msp_pkg::NUM_STACKS; i++) begin
        stack_top[i] <= msp_pkg::NIL_NODE;
      end
    end else begin
      if (m_tvalid && m_tready && !exec_go) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            state    <= S_IDLE;
            m_tvalid <= 1'b1;
            m_tuser  <= op_status;
            m_tdata  <= ((op_status == msp_pkg::ST_OK) && (op == msp_pkg::OP_POP)) ?
                        rd_value : '0;
            if (op_status == msp_pkg::ST_OK) begin
              if (op == msp_pkg::OP_POP) begin
                stack_top[op_stk] <= rd_next;
                free_head         <= op_node;
              end else begin
                stack_top[op_stk] <= op_node;
                if (op_from_free) begin
                  free_head <= rd_next;
                end else begin
                  fresh_next <= fresh_next + 1'b1;
                end
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> (state == S_EXEC))
    else $error("accepted beat did not enter execution");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != msp_pkg::ST_OK)) |-> (m_tdata == '0))
    else $error("failed operation returned a non-zero value");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == msp_pkg::ST_OK || m_tuser == msp_pkg::ST_EMPTY ||
                  m_tuser == msp_pkg::ST_FULL))
    else $error("undefined status code");

  a_free_used: assert property (@(posedge clk) disable iff (rst)
    (free_head < msp_pkg::NIL_NODE) |-> (free_head < fresh_next))
    else $error("free list holds a node never allocated");

endmodule

@@ tb/tb.sv @@
// Testbench for multi_stack_shared_pool: random push/pop traffic against a scoreboard.
`timescale 1ns / 1ps
module tb;

  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PCT = 36;
  localparam int RUN_SEGMENTS = 4;
  localparam int SEGMENT_OPS = 470;

  typedef struct packed {
    logic [msp_pkg::VALUE_W-1:0] value;
    msp_pkg::status_t status;
  } reply_t;

  class stack_pool_book;
    logic [msp_pkg::NODE_W-1:0] top_node[msp_pkg::NUM_STACKS];
    logic [msp_pkg::VALUE_W-1:0] node_val[msp_pkg::POOL_NODES];
    logic [msp_pkg::NODE_W-1:0] node_link[msp_pkg::POOL_NODES];
    logic [msp_pkg::NODE_W-1:0] free_head;
    logic [msp_pkg::NODE_W-1:0] fresh_node;
    reply_t replies_due[$];
    int errors;

    function new();
      foreach (top_node[i]) top_node[i] = msp_pkg::NIL_NODE;
      free_head = msp_pkg::NIL_NODE;
      fresh_node = '0;
      errors = 0;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    task report(string what);
      errors++;
      $display("ERROR at %0t: %s", $time, what);
    endtask

    // Operation beat accepted: update the shadow pool and queue the reply.
    function void note_op(msp_pkg::op_t op, logic [msp_pkg::SEL_W-1:0] sel,
                          logic [msp_pkg::VALUE_W-1:0] v);
      reply_t r;
      logic [msp_pkg::NODE_W-1:0] n;
      r.value = '0;
      r.status = msp_pkg::ST_OK;
      n = msp_pkg::NIL_NODE;
      if (op == msp_pkg::OP_PUSH) begin
        if (int'(sel) >= msp_pkg::NUM_STACKS) begin
          r.status = msp_pkg::ST_FULL;
        end else if (free_head != msp_pkg::NIL_NODE) begin
          n = free_head;
          free_head = node_link[n[msp_pkg::ADDR_W-1:0]];
        end else if (fresh_node != msp_pkg::NIL_NODE) begin
          n = fresh_node;
          fresh_node = fresh_node + 1'b1;
        end else begin
          r.status = msp_pkg::ST_FULL;
        end
        if (r.status == msp_pkg::ST_OK) begin
          node_val[n[msp_pkg::ADDR_W-1:0]] = v;
          node_link[n[msp_pkg::ADDR_W-1:0]] = top_node[sel];
          top_node[sel] = n;
        end
      end else begin
        if (int'(sel) >= msp_pkg::NUM_STACKS || top_node[sel] == msp_pkg::NIL_NODE) begin
          r.status = msp_pkg::ST_EMPTY;
        end else begin
          n = top_node[sel];
          r.value = node_val[n[msp_pkg::ADDR_W-1:0]];
          top_node[sel] = node_link[n[msp_pkg::ADDR_W-1:0]];
          node_link[n[msp_pkg::ADDR_W-1:0]] = free_head;
          free_head = n;
        end
      end
      replies_due.push_back(r);
    endfunction

    task check_reply(logic [msp_pkg::VALUE_W-1:0] got_value, logic [1:0] got_status);
      reply_t r;
      if (replies_due.size() == 0) begin
        report($sformatf("result beat with nothing pending (%h, %0d)",
                         got_value, got_status));
        return;
      end
      r = replies_due.pop_front();
      if (got_value !== r.value)
        report($sformatf("pop value %h, want %h", got_value, r.value));
      if (got_status !== r.status)
        report($sformatf("status %0d, want %0d", got_status, r.status));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic [3:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0] m_tuser;

  stack_pool_book book;
  bit steady = 1'b0;
  int quiet_cycles = 0;

  multi_stack_shared_pool dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_op(msp_pkg::op_t op, logic [msp_pkg::SEL_W-1:0] sel, logic [31:0] v);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser <= {sel, op};
    s_tdata <= v;
    do @(posedge clk); while (!s_tready);
    book.note_op(op, sel, v);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) book.check_reply(m_tdata, m_tuser);
    m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no beat moved for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int push_pct;
    int k;
    msp_pkg::op_t op;
    book = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty pops, extreme values, LIFO order, free-list reuse
    send_op(msp_pkg::OP_POP, 3'd0, 32'hFFFF_FFFF);
    send_op(msp_pkg::OP_POP, 3'd7, 32'h0);
    send_op(msp_pkg::OP_PUSH, 3'd0, 32'h7FFF_FFFF);
    send_op(msp_pkg::OP_PUSH, 3'd0, 32'h8000_0000);
    send_op(msp_pkg::OP_PUSH, 3'd7, 32'h0000_0000);
    send_op(msp_pkg::OP_PUSH, 3'd7, 32'hFFFF_FFFF);
    send_op(msp_pkg::OP_PUSH, 3'd3, 32'h0000_0001);
    send_op(msp_pkg::OP_POP, 3'd0, 32'h5555_5555);
    send_op(msp_pkg::OP_POP, 3'd0, 32'hAAAA_AAAA);
    send_op(msp_pkg::OP_POP, 3'd0, 32'h0);
    send_op(msp_pkg::OP_POP, 3'd7, 32'h0);
    send_op(msp_pkg::OP_PUSH, 3'd5, 32'h1234_5678);
    send_op(msp_pkg::OP_PUSH, 3'd5, 32'hFEDC_BA98);
    send_op(msp_pkg::OP_PUSH, 3'd5, 32'h0F0F_0F0F);
    send_op(msp_pkg::OP_POP, 3'd5, 32'h0);
    send_op(msp_pkg::OP_POP, 3'd3, 32'h0);
    send_op(msp_pkg::OP_POP, 3'd3, 32'h0);
    send_op(msp_pkg::OP_PUSH, 3'd3, 32'hC0DE_0001);

    // alternate fill-heavy and drain-heavy runs: pool full, then empty stacks
    for (int seg = 0; seg < RUN_SEGMENTS; seg++) begin
      push_pct = (seg % 2 == 0) ? 85 : 15;
      for (k = 0; k < SEGMENT_OPS; k++) begin
        steady = (seg == 2) && (k >= 100) && (k < 400);
        op = ($urandom_range(99) < push_pct) ? msp_pkg::OP_PUSH : msp_pkg::OP_POP;
        send_op(op, msp_pkg::SEL_W'($urandom_range(msp_pkg::NUM_STACKS - 1)), $urandom());
      end
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;

    while (book.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (book.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
